>>> src/gsu_pkg.sv
package gsu_pkg;

   // Message-level constants of the decoder
   localparam logic [7:0] OUTPUT_LIMIT  = 8'd160;
   localparam logic [6:0] ESC_CODE      = 7'h1B;
   localparam logic [6:0] EURO_EXT_CODE = 7'h65;
   localparam logic [7:0] UNMAPPED_BYTE = 8'h3F;

   // One input octet yields at most two whole septets plus one partial septet
   localparam int CHAR_SLOTS  = 3;
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic       ext;
      logic [6:0] code;
   } char_type;

   typedef struct packed {
      char_type [CHAR_SLOTS-1:0] chars;
      logic [1:0]                n_chars;
      logic                      close;
      logic [7:0]                length;
   } entry_type;

   // GSM default alphabet to Unicode code point
   localparam logic [10:0] BASE_TABLE [128] = '{
      11'h040, 11'h0A3, 11'h024, 11'h0A5, 11'h0E8, 11'h0E9, 11'h0F9, 11'h0EC,
      11'h0F2, 11'h0C7, 11'h00A, 11'h0D8, 11'h0F8, 11'h00D, 11'h0C5, 11'h0E5,
      11'h394, 11'h05F, 11'h3A6, 11'h393, 11'h39B, 11'h3A9, 11'h3A0, 11'h3A8,
      11'h3A3, 11'h398, 11'h39E, 11'h01B, 11'h0C6, 11'h0E6, 11'h0DF, 11'h0C9,
      11'h020, 11'h021, 11'h022, 11'h023, 11'h0A4, 11'h025, 11'h026, 11'h027,
      11'h028, 11'h029, 11'h02A, 11'h02B, 11'h02C, 11'h02D, 11'h02E, 11'h02F,
      11'h030, 11'h031, 11'h032, 11'h033, 11'h034, 11'h035, 11'h036, 11'h037,
      11'h038, 11'h039, 11'h03A, 11'h03B, 11'h03C, 11'h03D, 11'h03E, 11'h03F,
      11'h0A1, 11'h041, 11'h042, 11'h043, 11'h044, 11'h045, 11'h046, 11'h047,
      11'h048, 11'h049, 11'h04A, 11'h04B, 11'h04C, 11'h04D, 11'h04E, 11'h04F,
      11'h050, 11'h051, 11'h052, 11'h053, 11'h054, 11'h055, 11'h056, 11'h057,
      11'h058, 11'h059, 11'h05A, 11'h0C4, 11'h0D6, 11'h0D1, 11'h0DC, 11'h0A7,
      11'h0BF, 11'h061, 11'h062, 11'h063, 11'h064, 11'h065, 11'h066, 11'h067,
      11'h068, 11'h069, 11'h06A, 11'h06B, 11'h06C, 11'h06D, 11'h06E, 11'h06F,
      11'h070, 11'h071, 11'h072, 11'h073, 11'h074, 11'h075, 11'h076, 11'h077,
      11'h078, 11'h079, 11'h07A, 11'h0E4, 11'h0F6, 11'h0F1, 11'h0FC, 11'h0E0
   };

   // Extension table; codes without an entry give '?'
   function automatic logic [7:0] ext_byte(input logic [6:0] code);
      logic [7:0] b;
      begin
         unique case (code)
            7'h0A:   b = 8'h0C;
            7'h14:   b = 8'h5E;
            7'h28:   b = 8'h7B;
            7'h29:   b = 8'h7D;
            7'h2F:   b = 8'h5C;
            7'h3C:   b = 8'h5B;
            7'h3D:   b = 8'h7E;
            7'h3E:   b = 8'h5D;
            7'h40:   b = 8'h7C;
            default: b = UNMAPPED_BYTE;
         endcase
         return b;
      end
   endfunction

   // Number of UTF-8 bytes for one decoded character
   function automatic logic [1:0] char_len(input logic ext, input logic [6:0] code);
      logic [10:0] ucs;
      begin
         ucs = BASE_TABLE[code];
         if (ext) begin
            return (code == EURO_EXT_CODE) ? 2'd3 : 2'd1;
         end
         return (ucs[10:7] == 4'd0) ? 2'd1 : 2'd2;
      end
   endfunction

   // UTF-8 byte at position pos of one decoded character
   function automatic logic [7:0] char_byte(input logic ext, input logic [6:0] code,
                                            input logic [1:0] pos);
      logic [10:0] ucs;
      logic [7:0]  b;
      begin
         ucs = BASE_TABLE[code];
         if (ext) begin
            if (code == EURO_EXT_CODE) begin
               unique case (pos)
                  2'd0:    b = 8'hE2;
                  2'd1:    b = 8'h82;
                  default: b = 8'hAC;
               endcase
            end else begin
               b = ext_byte(code);
            end
         end else if (ucs[10:7] == 4'd0) begin
            b = ucs[7:0];
         end else if (pos == 2'd0) begin
            b = {3'b110, ucs[10:6]};
         end else begin
            b = {2'b10, ucs[5:0]};
         end
         return b;
      end
   endfunction

endpackage

>>> src/gsm7_septet_unpack_to_utf8_core.sv
// GSM 7-bit septet unpacker with UTF-8 output. Feed packed SMS user-data
// octets one per transaction, least significant bit first; first_of_message
// on the opening octet clears the decoder and loads septet_total. Each octet
// is cut into septets and every character comes out as one to three UTF-8
// bytes on the rsp_ channel, one byte per transaction; an octet with
// last_of_message adds a closing transaction with message_end and the byte
// count in text_length. run_last marks the final transaction caused by each
// input octet; octets that decode to nothing (escape, past the end, after
// the limit) cause no transaction. Rate: the front end takes one octet per
// cycle while its four-entry queue has room, and the back end emits one
// UTF-8 byte per cycle while the queue holds an entry and rsp_stall does not
// hold the output; an octet makes zero to six output transactions, typically
// one or two, with the output byte serializer setting the sustained rate.
// rsp_stall holds the output register and, once the queue fills, stalls the input.
module gsm7_septet_unpack_to_utf8_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_first_of_message,
   input  logic       req_last_of_message,
   input  logic [8:0] req_septet_total,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_text_byte,
   output logic       rsp_byte_valid,
   output logic       rsp_message_end,
   output logic [7:0] rsp_text_length,
   output logic       rsp_run_last
);

   logic               q_push;
   gsu_pkg::entry_type q_push_entry;
   logic               q_full;
   logic               q_pop;
   gsu_pkg::entry_type q_head;
   logic               q_empty;

   // Stall input only when the queue between front and back is full
   assign req_stall = q_full;

   // Front: unpack septets, apply limits and escape, track byte count
   gsu_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .accept_ok        (!q_full),
      .data_byte        (req_data_byte),
      .first_of_message (req_first_of_message),
      .last_of_message  (req_last_of_message),
      .septet_total     (req_septet_total),
      .push             (q_push),
      .push_entry       (q_push_entry)
   );

   // Decouple the two halves
   gsu_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   // Back: expand characters to UTF-8 bytes and emit the closing transaction
   gsu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (q_head),
      .empty           (q_empty),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_byte   (rsp_text_byte),
      .rsp_byte_valid  (rsp_byte_valid),
      .rsp_message_end (rsp_message_end),
      .rsp_text_length (rsp_text_length),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

>>> src/gsu_front.sv
module gsu_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                accept_ok,
   input  logic [7:0]          data_byte,
   input  logic                first_of_message,
   input  logic                last_of_message,
   input  logic [8:0]          septet_total,
   output logic                push,
   output gsu_pkg::entry_type  push_entry
);

   logic [13:0] bit_buffer_ff, bit_buffer_in;
   logic [3:0]  bits_held_ff, bits_held_in;
   logic [8:0]  septet_index_ff, septet_index_in;
   logic [8:0]  septet_limit_ff, septet_limit_in;
   logic        escape_ff, escape_in;
   logic [7:0]  bytes_out_ff, bytes_out_in;
   logic        stopped_ff, stopped_in;

   gsu_pkg::char_type [gsu_pkg::CHAR_SLOTS-1:0] chars_v;
   logic [1:0]  n_v;
   logic        may_v;
   logic        step_v;
   logic [6:0]  val_v;
   logic [1:0]  len_v;
   logic [8:0]  sum_v;
   logic        accept;

   assign accept = req_valid && accept_ok;

   // Cut the octet into septets and classify them; track all message counters
   always_comb begin
      bit_buffer_in   = bit_buffer_ff;
      bits_held_in    = bits_held_ff;
      septet_index_in = septet_index_ff;
      septet_limit_in = septet_limit_ff;
      escape_in       = escape_ff;
      bytes_out_in    = bytes_out_ff;
      stopped_in      = stopped_ff;
      chars_v         = '0;
      n_v             = 2'd0;
      may_v           = 1'b0;
      step_v          = 1'b0;
      val_v           = 7'd0;
      len_v           = 2'd0;
      sum_v           = 9'd0;
      if (first_of_message) begin
         bit_buffer_in   = 14'd0;
         bits_held_in    = 4'd0;
         septet_index_in = 9'd0;
         septet_limit_in = septet_total;
         escape_in       = 1'b0;
         bytes_out_in    = 8'd0;
         stopped_in      = 1'b0;
      end
      if (!stopped_in) begin
         bit_buffer_in = bit_buffer_in | ({6'd0, data_byte} << bits_held_in[2:0]);
         bits_held_in  = bits_held_in + 4'd8;
      end
      for (int k = 0; k < gsu_pkg::CHAR_SLOTS; k++) begin
         may_v = escape_in ||
                 (septet_index_in < septet_limit_in && bytes_out_in < gsu_pkg::OUTPUT_LIMIT);
         if (k < gsu_pkg::CHAR_SLOTS - 1) begin
            step_v = !stopped_in && bits_held_in >= 4'd7;
            if (step_v && !may_v) begin
               stopped_in = 1'b1;
               step_v     = 1'b0;
            end
         end else begin
            // partial septet left at the final octet
            step_v = last_of_message && !stopped_in && bits_held_in != 4'd0 && may_v;
         end
         if (step_v) begin
            val_v = bit_buffer_in[6:0];
            if (k < gsu_pkg::CHAR_SLOTS - 1) begin
               bit_buffer_in = bit_buffer_in >> 7;
               bits_held_in  = bits_held_in - 4'd7;
            end
            if (septet_index_in != 9'h1FF) begin
               septet_index_in = septet_index_in + 9'd1;
            end
            if (escape_in || val_v != gsu_pkg::ESC_CODE) begin
               len_v            = gsu_pkg::char_len(escape_in, val_v);
               chars_v[n_v]     = '{ext: escape_in, code: val_v};
               n_v              = n_v + 2'd1;
               sum_v            = {1'b0, bytes_out_in} + {7'd0, len_v};
               bytes_out_in     = sum_v[8] ? 8'hFF : sum_v[7:0];
               escape_in        = 1'b0;
            end else begin
               escape_in = 1'b1;
            end
         end
      end
      if (last_of_message) begin
         bit_buffer_in = 14'd0;
         bits_held_in  = 4'd0;
         stopped_in    = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_buffer_ff   <= 14'd0;
         bits_held_ff    <= 4'd0;
         septet_index_ff <= 9'd0;
         septet_limit_ff <= 9'd0;
         escape_ff       <= 1'b0;
         bytes_out_ff    <= 8'd0;
         stopped_ff      <= 1'b0;
      end else if (accept) begin
         bit_buffer_ff   <= bit_buffer_in;
         bits_held_ff    <= bits_held_in;
         septet_index_ff <= septet_index_in;
         septet_limit_ff <= septet_limit_in;
         escape_ff       <= escape_in;
         bytes_out_ff    <= bytes_out_in;
         stopped_ff      <= stopped_in;
      end
   end

   // Drop transactions that produce nothing
   assign push               = accept && (n_v != 2'd0 || last_of_message);
   assign push_entry.chars   = chars_v;
   assign push_entry.n_chars = n_v;
   assign push_entry.close   = last_of_message;
   assign push_entry.length  = bytes_out_in;

endmodule

>>> src/gsu_queue.sv
module gsu_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gsu_pkg::entry_type  push_entry,
   output logic                full,
   input  logic                pop,
   output gsu_pkg::entry_type  head,
   output logic                empty
);

   localparam int AW = $clog2(gsu_pkg::QUEUE_DEPTH);

   gsu_pkg::entry_type mem_ff [gsu_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   assign full  = (count_ff == (AW + 1)'(gsu_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (AW + 1)'(push) - (AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset) full |-> !push || pop)
      else $error("queue push while full");
   assert property (@(posedge clock) disable iff (reset) empty |-> !pop)
      else $error("queue pop while empty");
`endif

endmodule

>>> src/gsu_back.sv
module gsu_back (
   input  logic                clock,
   input  logic                reset,
   input  gsu_pkg::entry_type  head,
   input  logic                empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_text_byte,
   output logic                rsp_byte_valid,
   output logic                rsp_message_end,
   output logic [7:0]          rsp_text_length,
   output logic                rsp_run_last
);

   logic [1:0] slot_ff, slot_in;
   logic [1:0] pos_ff, pos_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] text_byte_ff, text_byte_in;
   logic       byte_valid_ff, byte_valid_in;
   logic       message_end_ff, message_end_in;
   logic [7:0] text_length_ff, text_length_in;
   logic       run_last_ff, run_last_in;

   gsu_pkg::char_type cur;
   logic [1:0] len;
   logic       in_close;
   logic       last_byte;
   logic       load_ok;
   logic       fire;

   always_comb begin
      unique case (slot_ff)
         2'd0:    cur = head.chars[0];
         2'd1:    cur = head.chars[1];
         default: cur = head.chars[2];
      endcase
      in_close  = (slot_ff == head.n_chars);
      len       = gsu_pkg::char_len(cur.ext, cur.code);
      last_byte = (pos_ff == len - 2'd1);
      load_ok   = !rsp_valid_ff || !rsp_stall;
      fire      = !empty && load_ok;
      pop       = fire && (in_close ||
                           (last_byte && slot_ff + 2'd1 == head.n_chars && !head.close));

      slot_in        = slot_ff;
      pos_in         = pos_ff;
      rsp_valid_in   = rsp_valid_ff && !load_ok;
      text_byte_in   = text_byte_ff;
      byte_valid_in  = byte_valid_ff;
      message_end_in = message_end_ff;
      text_length_in = text_length_ff;
      run_last_in    = run_last_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         if (in_close) begin
            text_byte_in   = 8'd0;
            byte_valid_in  = 1'b0;
            message_end_in = 1'b1;
            text_length_in = head.length;
            run_last_in    = 1'b1;
         end else begin
            text_byte_in   = gsu_pkg::char_byte(cur.ext, cur.code, pos_ff);
            byte_valid_in  = 1'b1;
            message_end_in = 1'b0;
            text_length_in = 8'd0;
            run_last_in    = pop;
         end
         if (pop) begin
            slot_in = 2'd0;
            pos_in  = 2'd0;
         end else if (last_byte) begin
            slot_in = slot_ff + 2'd1;
            pos_in  = 2'd0;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff      <= 2'd0;
         pos_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         slot_ff      <= slot_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      text_byte_ff   <= text_byte_in;
      byte_valid_ff  <= byte_valid_in;
      message_end_ff <= message_end_in;
      text_length_ff <= text_length_in;
      run_last_ff    <= run_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_text_byte   = text_byte_ff;
   assign rsp_byte_valid  = byte_valid_ff;
   assign rsp_message_end = message_end_ff;
   assign rsp_text_length = text_length_ff;
   assign rsp_run_last    = run_last_ff;

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid_ff && message_end_ff |-> run_last_ff && !byte_valid_ff)
      else $error("closing result without run_last");
   assert property (@(posedge clock) disable iff (reset)
                    fire && !in_close |-> pos_ff < len)
      else $error("byte position past character length");
`endif

endmodule

>>> tb/tb_gsm7_septet_unpack_to_utf8_core.sv
`timescale 1ns / 100ps

module tb_gsm7_septet_unpack_to_utf8_core;

   localparam int WATCHDOG_LIMIT = 5000;  // cycles with no transaction on either side
   localparam int DRAIN_CYCLES   = 16;    // settle time after the last result
   localparam int PRESSURE_HOLD  = 400;   // receiver hold-off, long enough to fill the queue

   // Default alphabet as Unicode code points; all of them fit in two UTF-8 bytes
   localparam logic [10:0] GSM_TO_UCS [128] = '{
      11'h040, 11'h0A3, 11'h024, 11'h0A5, 11'h0E8, 11'h0E9, 11'h0F9, 11'h0EC,
      11'h0F2, 11'h0C7, 11'h00A, 11'h0D8, 11'h0F8, 11'h00D, 11'h0C5, 11'h0E5,
      11'h394, 11'h05F, 11'h3A6, 11'h393, 11'h39B, 11'h3A9, 11'h3A0, 11'h3A8,
      11'h3A3, 11'h398, 11'h39E, 11'h01B, 11'h0C6, 11'h0E6, 11'h0DF, 11'h0C9,
      11'h020, 11'h021, 11'h022, 11'h023, 11'h0A4, 11'h025, 11'h026, 11'h027,
      11'h028, 11'h029, 11'h02A, 11'h02B, 11'h02C, 11'h02D, 11'h02E, 11'h02F,
      11'h030, 11'h031, 11'h032, 11'h033, 11'h034, 11'h035, 11'h036, 11'h037,
      11'h038, 11'h039, 11'h03A, 11'h03B, 11'h03C, 11'h03D, 11'h03E, 11'h03F,
      11'h0A1, 11'h041, 11'h042, 11'h043, 11'h044, 11'h045, 11'h046, 11'h047,
      11'h048, 11'h049, 11'h04A, 11'h04B, 11'h04C, 11'h04D, 11'h04E, 11'h04F,
      11'h050, 11'h051, 11'h052, 11'h053, 11'h054, 11'h055, 11'h056, 11'h057,
      11'h058, 11'h059, 11'h05A, 11'h0C4, 11'h0D6, 11'h0D1, 11'h0DC, 11'h0A7,
      11'h0BF, 11'h061, 11'h062, 11'h063, 11'h064, 11'h065, 11'h066, 11'h067,
      11'h068, 11'h069, 11'h06A, 11'h06B, 11'h06C, 11'h06D, 11'h06E, 11'h06F,
      11'h070, 11'h071, 11'h072, 11'h073, 11'h074, 11'h075, 11'h076, 11'h077,
      11'h078, 11'h079, 11'h07A, 11'h0E4, 11'h0F6, 11'h0F1, 11'h0FC, 11'h0E0
   };

   // Extension codes that have a table entry, the euro sign included
   localparam logic [6:0] EXT_CODES [10] = '{
      7'h0A, 7'h14, 7'h28, 7'h29, 7'h2F, 7'h3C, 7'h3D, 7'h3E, 7'h40, 7'h65
   };

   typedef struct packed {
      logic [7:0] text_byte;
      logic       byte_valid;
      logic       message_end;
      logic [7:0] text_length;
      logic       run_last;
   } text_result_type;

   // DUT ports
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_first_of_message = 1'b0;
   logic       req_last_of_message = 1'b0;
   logic [8:0] req_septet_total = 9'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_text_byte;
   logic       rsp_byte_valid;
   logic       rsp_message_end;
   logic [7:0] rsp_text_length;
   logic       rsp_run_last;

   // Decoder mirror: unpacking state and message counters
   logic [13:0] bit_store;
   logic [3:0]  held_bits;
   logic [8:0]  septets_used;
   logic [8:0]  septet_budget;
   logic        escape_armed;
   logic [7:0]  out_count;
   logic        halted;

   text_result_type octet_results[$];   // results of the octet being predicted
   text_result_type expected_text[$];   // results still owed by the DUT
   logic [6:0]      septet_list[$];     // message under construction
   logic [7:0]      octet_list[$];      // same message packed into octets

   int  items_sent = 0;
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   int  sender_idle_pct = 0;
   int  receiver_stall_pct = 0;
   bit  hold_request = 1'b0;
   bit  hold_ack = 1'b0;
   int  hold_left = 0;

   gsm7_septet_unpack_to_utf8_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_data_byte        (req_data_byte),
      .req_first_of_message (req_first_of_message),
      .req_last_of_message  (req_last_of_message),
      .req_septet_total     (req_septet_total),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_text_byte        (rsp_text_byte),
      .rsp_byte_valid       (rsp_byte_valid),
      .rsp_message_end      (rsp_message_end),
      .rsp_text_length      (rsp_text_length),
      .rsp_run_last         (rsp_run_last)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Decoder prediction
   // ---------------------------------------------------------------------

   function void clear_decoder();
      bit_store     = '0;
      held_bits     = '0;
      septets_used  = '0;
      septet_budget = '0;
      escape_armed  = 1'b0;
      out_count     = '0;
      halted        = 1'b0;
   endfunction

   function text_result_type make_result(input logic [7:0] b, input logic is_byte,
                                         input logic is_end, input logic [7:0] len);
      text_result_type r;
      r.text_byte   = b;
      r.byte_valid  = is_byte;
      r.message_end = is_end;
      r.text_length = len;
      r.run_last    = 1'b0;
      return r;
   endfunction

   function void push_text(input logic [7:0] b);
      octet_results.push_back(make_result(b, 1'b1, 1'b0, 8'd0));
      if (out_count != 8'd255) out_count = out_count + 8'd1;
   endfunction

   function logic [7:0] ext_ascii(input logic [6:0] code);
      case (code)
         7'h0A:   return 8'h0C;
         7'h14:   return 8'h5E;
         7'h28:   return 8'h7B;
         7'h29:   return 8'h7D;
         7'h2F:   return 8'h5C;
         7'h3C:   return 8'h5B;
         7'h3D:   return 8'h7E;
         7'h3E:   return 8'h5D;
         7'h40:   return 8'h7C;
         default: return gsu_pkg::UNMAPPED_BYTE;
      endcase
   endfunction

   // An armed escape always lets the next septet through; a primary septet
   // needs both the septet count and the output budget
   function logic may_decode();
      return escape_armed ||
             (septets_used < septet_budget && out_count < gsu_pkg::OUTPUT_LIMIT);
   endfunction

   function void decode_septet(input logic [6:0] septet);
      logic [10:0] ucs;
      if (septets_used != 9'd511) septets_used = septets_used + 9'd1;
      if (escape_armed) begin
         escape_armed = 1'b0;
         if (septet == gsu_pkg::EURO_EXT_CODE) begin
            push_text(8'hE2);
            push_text(8'h82);
            push_text(8'hAC);
         end else begin
            push_text(ext_ascii(septet));
         end
      end else if (septet == gsu_pkg::ESC_CODE) begin
         escape_armed = 1'b1;
      end else begin
         ucs = GSM_TO_UCS[septet];
         if (ucs <= 11'h07F) begin
            push_text(ucs[7:0]);
         end else begin
            push_text({3'b110, ucs[10:6]});
            push_text({2'b10, ucs[5:0]});
         end
      end
   endfunction

   // Work out every result one accepted octet causes and queue them
   function void predict_octet(input logic [7:0] data, input logic first,
                               input logic last, input logic [8:0] total);
      logic [15:0] merged;
      logic [6:0]  septet;
      octet_results.delete();
      if (first) begin
         clear_decoder();
         septet_budget = total;
      end
      if (!halted) begin
         merged    = {2'b00, bit_store} | ({8'h00, data} << held_bits);
         bit_store = merged[13:0];
         held_bits = held_bits + 4'd8;
         while (held_bits >= 4'd7) begin
            if (!may_decode()) begin
               halted = 1'b1;
               break;
            end
            septet    = bit_store[6:0];
            bit_store = bit_store >> 7;
            held_bits = held_bits - 4'd7;
            decode_septet(septet);
         end
      end
      if (last) begin
         // leftover bits of the final octet form one more septet, upper bits zero
         if (!halted && held_bits != 4'd0 && may_decode()) decode_septet(bit_store[6:0]);
         bit_store = '0;
         held_bits = '0;
         halted    = 1'b1;
         octet_results.push_back(make_result(8'h00, 1'b0, 1'b1, out_count));
      end
      if (octet_results.size() != 0) octet_results[octet_results.size() - 1].run_last = 1'b1;
      foreach (octet_results[i]) expected_text.push_back(octet_results[i]);
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   // Pack septet_list LSB first; fill the unused top of the final octet randomly
   function void pack_septets();
      logic [15:0] acc;
      logic [7:0]  fill;
      int          nbits;
      octet_list.delete();
      acc   = '0;
      nbits = 0;
      foreach (septet_list[i]) begin
         acc   = acc | ({9'd0, septet_list[i]} << nbits);
         nbits = nbits + 7;
         while (nbits >= 8) begin
            octet_list.push_back(acc[7:0]);
            acc   = acc >> 8;
            nbits = nbits - 8;
         end
      end
      if (nbits > 0) begin
         fill = 8'($urandom_range(255));
         fill = fill << nbits;
         octet_list.push_back(acc[7:0] | fill);
      end
   endfunction

   // Offer one octet, hold it until accepted, then maybe go idle for a while.
   // Always entered right after a rising edge.
   task automatic send_octet(input logic [7:0] data, input logic first,
                             input logic last, input logic [8:0] total);
      req_valid            <= 1'b1;
      req_data_byte        <= data;
      req_first_of_message <= first;
      req_last_of_message  <= last;
      req_septet_total     <= total;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_octet(data, first, last, total);
      items_sent++;
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < sender_idle_pct) @(posedge clock);
      end
   endtask

   // Send octet_list as one message; septet_total is random on later octets
   task automatic send_message(input logic [8:0] total, input bit with_last);
      int i;
      for (i = 0; i < octet_list.size(); i++) begin
         send_octet(octet_list[i], i == 0, with_last && (i == octet_list.size() - 1),
                    (i == 0) ? total : 9'($urandom_range(511)));
      end
   endtask

   task automatic build_and_send(input logic [8:0] total);
      pack_septets();
      send_message(total, 1'b1);
   endtask

   // Random message: mostly well formed, with escapes, odd totals, cut-off
   // messages, octets after the end and stray octets with random flags
   task automatic send_random_message();
      int          n;
      int          pick;
      int          cut;
      logic [8:0]  total;
      septet_list.delete();
      n = $urandom_range(1, 24);
      while (septet_list.size() < n) begin
         if ($urandom_range(99) < 15) begin
            septet_list.push_back(gsu_pkg::ESC_CODE);
            if ($urandom_range(1) == 1) septet_list.push_back(EXT_CODES[$urandom_range(9)]);
            else septet_list.push_back(7'($urandom_range(127)));
         end else begin
            septet_list.push_back(7'($urandom_range(127)));
         end
      end
      if ($urandom_range(99) < 8) septet_list.push_back(gsu_pkg::ESC_CODE);
      n    = septet_list.size();
      pick = $urandom_range(99);
      if (pick < 60)      total = 9'(n);
      else if (pick < 75) total = 9'($urandom_range(n));
      else if (pick < 85) total = 9'(n + $urandom_range(1, 3));
      else if (pick < 95) total = 9'($urandom_range(511));
      else                total = 9'd0;
      pack_septets();

      pick = $urandom_range(99);
      if (pick < 5) begin
         send_octet(8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
                    9'($urandom_range(511)));
      end
      if (pick >= 5 && pick < 15) begin
         // cut the message short and leave it open
         cut = $urandom_range(1, octet_list.size());
         while (octet_list.size() > cut) void'(octet_list.pop_back());
         send_message(total, 1'b0);
      end else begin
         send_message(total, 1'b1);
      end
      if (pick >= 15 && pick < 30) begin
         repeat ($urandom_range(1, 3)) begin
            send_octet(8'($urandom_range(255)), 1'b0, ($urandom_range(3) == 0),
                       9'($urandom_range(511)));
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // No start since reset: the septet count is zero, so only the close comes out
   task automatic test_reset_without_start();
      send_octet(8'hFF, 1'b0, 1'b0, 9'h1FF);
      send_octet(8'h00, 1'b0, 1'b1, 9'd0);
   endtask

   task automatic test_zero_total();
      send_octet(8'hA5, 1'b1, 1'b1, 9'd0);
   endtask

   // 0xFF alone: septet 0x7F plus one leftover bit; the partial septet
   // decodes only when the count allows it
   task automatic test_partial_last_septet();
      send_octet(8'hFF, 1'b1, 1'b1, 9'd2);
      send_octet(8'hFF, 1'b1, 1'b1, 9'd1);
   endtask

   task automatic test_escape_handling();
      // euro, unmapped extension codes at both ends, a mapped one
      septet_list = '{gsu_pkg::ESC_CODE, gsu_pkg::EURO_EXT_CODE, gsu_pkg::ESC_CODE, 7'h00,
                      gsu_pkg::ESC_CODE, 7'h28, gsu_pkg::ESC_CODE, 7'h7F};
      build_and_send(9'd8);
      // the code after an escape is read past the septet count
      septet_list = '{gsu_pkg::ESC_CODE, 7'h3C, 7'h41};
      build_and_send(9'd1);
      // data ends exactly on an escape: nothing comes out for it
      septet_list = '{7'h00, 7'h7F, 7'h20, 7'h41, 7'h61, 7'h10, 7'h11,
                      gsu_pkg::ESC_CODE};
      build_and_send(9'd511);
   endtask

   // Octets after the close are dropped; another last flag closes again
   task automatic test_octets_after_end();
      send_octet(8'h41, 1'b0, 1'b0, 9'd77);
      send_octet(8'hC3, 1'b0, 1'b1, 9'd0);
   endtask

   // Drive the output to the byte limit with two-byte characters and end on
   // a euro sign, so the text overshoots by one and by two bytes
   task automatic test_output_limit();
      int lead;
      for (lead = 0; lead < 2; lead++) begin
         septet_list.delete();
         if (lead == 1) septet_list.push_back(7'h41);
         repeat (79) septet_list.push_back(7'($urandom_range(8'h12, 8'h1A)));
         septet_list.push_back(gsu_pkg::ESC_CODE);
         septet_list.push_back(gsu_pkg::EURO_EXT_CODE);
         repeat (4) septet_list.push_back(7'($urandom_range(127)));
         build_and_send(9'd300);
      end
   endtask

   task automatic test_random_traffic(input int n_items, input int idle_pct, input int stall_pct);
      int stop_at;
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) send_random_message();
   endtask

   // Hold the receiver off while the sender keeps offering, so the internal
   // queue fills and the input stalls
   task automatic test_backpressure();
      int stop_at;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_request <= ~hold_request;
      stop_at = items_sent + 40;
      while (items_sent < stop_at) send_random_message();
   endtask

   initial begin
      clear_decoder();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_without_start();
      test_zero_total();
      test_partial_last_septet();
      test_escape_handling();
      test_octets_after_end();
      test_output_limit();
      test_random_traffic(50, 0, 0);
      test_random_traffic(50, 74, 0);
      test_random_traffic(50, 0, 74);
      test_random_traffic(50, 29, 29);
      test_backpressure();

      // drop valid and drain; the watchdog catches a hang here
      req_valid <= 1'b0;
      while (expected_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("gsm7_septet_unpack_to_utf8_core regression: pass");
      end else begin
         $display("gsm7_septet_unpack_to_utf8_core regression: fail");
      end
      $finish;
   end

   // ---------------------------------------------------------------------
   // Receiver: random stall, or a long hold-off counted here
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request != hold_ack) begin
         hold_ack  <= hold_request;
         hold_left <= PRESSURE_HOLD - 1;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------
   task report_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("[%0t] text mismatch on %s: got 0x%0h, expected 0x%0h",
               $time, what, got, want);
   endtask

   // Compare each accepted transaction with the oldest expectation
   always @(posedge clock) begin : check_text
      text_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_text.size() == 0) begin
            report_mismatch("transaction with nothing pending", rsp_text_byte, 0);
         end else begin
            want = expected_text.pop_front();
            if (rsp_text_byte !== want.text_byte)
               report_mismatch("text_byte", rsp_text_byte, want.text_byte);
            if (rsp_byte_valid !== want.byte_valid)
               report_mismatch("byte_valid", rsp_byte_valid, want.byte_valid);
            if (rsp_message_end !== want.message_end)
               report_mismatch("message_end", rsp_message_end, want.message_end);
            if (rsp_text_length !== want.text_length)
               report_mismatch("text_length", rsp_text_length, want.text_length);
            if (rsp_run_last !== want.run_last)
               report_mismatch("run_last", rsp_run_last, want.run_last);
         end
      end
   end

   // Watchdog: advance on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[%0t] watchdog: no transaction for %0d cycles, %0d results pending",
                  $time, WATCHDOG_LIMIT, expected_text.size());
         $display("gsm7_septet_unpack_to_utf8_core regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
